/* rtl/hsvws_pkg.sv */
// shared types and constants for the hsv window statistics block
package hsvws_pkg;

   localparam int MAX_PIXELS = 8192;
   localparam int COUNT_W    = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W      = $clog2(MAX_PIXELS * 255 + 1);
   localparam int CHAN_W     = 8;
   localparam int MEAN_W     = 8;
   localparam int DIV_STEPS  = MEAN_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [CHAN_W-1:0] HUE_SPLIT_RESET = 8'd89;
   localparam logic [CHAN_W-1:0] CHAN_MAX        = 8'd255;
   localparam logic [CHAN_W-1:0] CHAN_MIN        = 8'd0;

   typedef struct packed {
      logic [CHAN_W-1:0] hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  hue_min;
      logic [CHAN_W-1:0]  hue_max;
      logic [CHAN_W-1:0]  sat_min;
      logic [CHAN_W-1:0]  sat_max;
      logic [SUM_W-1:0]   sat_sum;
      logic [CHAN_W-1:0]  bright_min;
      logic [CHAN_W-1:0]  bright_max;
      logic [SUM_W-1:0]   bright_sum;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } stats_type;

endpackage

/* rtl/hsv_window_color_statistics_unit.sv */
// hsv window statistics: top level with sequencer, result register and csr
// a word without tlast leaves the unit accumulating and ready for another word
// a word with tlast starts two 8-step divisions on one shared divider; the result
// word is offered once both divisions are done, no words taken meanwhile
// further words are taken while a result waits, but a new tlast word waits for it
// reset (synchronous, active high) sets hue_split to 89 and clears the running statistics
module hsv_window_color_statistics_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata,    // hue_split
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // hue, saturation, brightness
   input  logic        req_tlast,    // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // hue_upper_min, hue_lower_max, sat_min, sat_max,
                                     // sat_mean, bright_min, bright_max, bright_mean
   output logic        rsp_tuser     // overflow
);

   localparam int CW = hsvws_pkg::CHAN_W;

   typedef enum logic [1:0] {
      ST_ACC,
      ST_DIV_SAT,
      ST_DIV_BRIGHT
   } state_type;

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  split_ff, split_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   hsvws_pkg::stats_type           res_ff, res_in;
   logic [hsvws_pkg::MEAN_W-1:0]   sat_mean_ff, sat_mean_in;
   logic [hsvws_pkg::MEAN_W-1:0]   bright_mean_ff, bright_mean_in;

   hsvws_pkg::pixel_type           pixel;
   hsvws_pkg::stats_type           stats_upd;
   logic                           req_accept;
   logic                           div_start;
   logic [hsvws_pkg::SUM_W-1:0]    div_dividend;
   logic                           div_done;
   logic [hsvws_pkg::MEAN_W-1:0]   div_quotient;

   // first division starts the cycle after the closing word, from the captured sums
   logic                           sat_go_ff;
   logic                           start_mux;
   logic [hsvws_pkg::SUM_W-1:0]    dividend_mux;

   assign pixel.hue        = req_tdata[CW-1:0];
   assign pixel.saturation = req_tdata[2*CW-1:CW];
   assign pixel.brightness = req_tdata[3*CW-1:2*CW];

   assign csr_ready  = 1'b1;
   assign split_in   = csr_valid ? csr_wdata : split_ff;

   // a closing word needs the result register free, or freed at this edge
   assign req_tready = (state_ff == ST_ACC)
                       && (!req_tlast || !rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   hsvws_accumulator u_acc (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .last      (req_tlast),
      .pixel     (pixel),
      .hue_split (split_ff),
      .stats_upd (stats_upd)
   );

   hsvws_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_mux),
      .dividend (dividend_mux),
      .divisor  (res_ff.count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      res_in         = res_ff;
      sat_mean_in    = sat_mean_ff;
      bright_mean_in = bright_mean_ff;
      div_start      = 1'b0;
      div_dividend   = res_ff.sat_sum;
      unique case (state_ff)
         ST_ACC: begin
            if (req_accept && req_tlast) begin
               res_in   = stats_upd;
               state_in = ST_DIV_SAT;
            end
         end
         ST_DIV_SAT: begin
            if (div_done) begin
               sat_mean_in  = div_quotient;
               div_start    = 1'b1;
               div_dividend = res_ff.bright_sum;
               state_in     = ST_DIV_BRIGHT;
            end
         end
         ST_DIV_BRIGHT: begin
            if (div_done) begin
               bright_mean_in = div_quotient;
               rsp_valid_in   = 1'b1;
               state_in       = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         split_ff     <= hsvws_pkg::HUE_SPLIT_RESET;
         rsp_valid_ff <= 1'b0;
         sat_go_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         split_ff     <= split_in;
         rsp_valid_ff <= rsp_valid_in;
         sat_go_ff    <= (state_ff == ST_ACC) && (state_in == ST_DIV_SAT);
      end
      res_ff         <= res_in;
      sat_mean_ff    <= sat_mean_in;
      bright_mean_ff <= bright_mean_in;
   end

   assign start_mux    = div_start || sat_go_ff;
   assign dividend_mux = sat_go_ff ? res_ff.sat_sum : div_dividend;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {bright_mean_ff, res_ff.bright_max, res_ff.bright_min, sat_mean_ff,
                        res_ff.sat_max, res_ff.sat_min, res_ff.hue_max, res_ff.hue_min};
   assign rsp_tuser  = res_ff.overflow;

endmodule

/* rtl/hsvws_accumulator.sv */
// running min, max and sum registers for one window of pixels
module hsvws_accumulator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      last,
   input  hsvws_pkg::pixel_type      pixel,
   input  logic [hsvws_pkg::CHAN_W-1:0] hue_split,
   output hsvws_pkg::stats_type      stats_upd
);

   hsvws_pkg::stats_type stats_ff;
   hsvws_pkg::stats_type stats_in;
   hsvws_pkg::stats_type stats_clr;
   logic                 room;

   always_comb begin
      stats_clr            = '0;
      stats_clr.hue_min    = hsvws_pkg::CHAN_MAX;
      stats_clr.hue_max    = hsvws_pkg::CHAN_MIN;
      stats_clr.sat_min    = hsvws_pkg::CHAN_MAX;
      stats_clr.sat_max    = hsvws_pkg::CHAN_MIN;
      stats_clr.bright_min = hsvws_pkg::CHAN_MAX;
      stats_clr.bright_max = hsvws_pkg::CHAN_MIN;
   end

   assign room = (stats_ff.count < hsvws_pkg::COUNT_W'(hsvws_pkg::MAX_PIXELS));

   // figures including the current word
   always_comb begin
      stats_upd = stats_ff;
      if (room) begin
         if (pixel.hue < hue_split && pixel.hue > stats_ff.hue_max) begin
            stats_upd.hue_max = pixel.hue;
         end
         if (pixel.hue > hue_split && pixel.hue < stats_ff.hue_min) begin
            stats_upd.hue_min = pixel.hue;
         end
         if (pixel.saturation > stats_ff.sat_max) begin
            stats_upd.sat_max = pixel.saturation;
         end
         if (pixel.saturation < stats_ff.sat_min) begin
            stats_upd.sat_min = pixel.saturation;
         end
         if (pixel.brightness > stats_ff.bright_max) begin
            stats_upd.bright_max = pixel.brightness;
         end
         if (pixel.brightness < stats_ff.bright_min) begin
            stats_upd.bright_min = pixel.brightness;
         end
         stats_upd.sat_sum    = stats_ff.sat_sum
                                + hsvws_pkg::SUM_W'(pixel.saturation);
         stats_upd.bright_sum = stats_ff.bright_sum
                                + hsvws_pkg::SUM_W'(pixel.brightness);
         stats_upd.count      = stats_ff.count + 1'b1;
      end else begin
         stats_upd.overflow = 1'b1;
      end
   end

   always_comb begin
      stats_in = stats_ff;
      if (accept) begin
         stats_in = last ? stats_clr : stats_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= stats_clr;
      end else begin
         stats_ff <= stats_in;
      end
   end

endmodule

/* rtl/hsvws_divider.sv */
// shared restoring divider, one quotient bit per cycle, for the window means
module hsvws_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hsvws_pkg::SUM_W-1:0]   dividend,
   input  logic [hsvws_pkg::COUNT_W-1:0] divisor,
   output logic                          done,
   output logic [hsvws_pkg::MEAN_W-1:0]  quotient
);

   localparam int SW = hsvws_pkg::SUM_W;

   logic                          busy_ff,  busy_in;
   logic                          done_ff,  done_in;
   logic [hsvws_pkg::STEP_W-1:0]  step_ff,  step_in;
   logic [SW-1:0]                 rem_ff,   rem_in;
   logic [SW-1:0]                 dsh_ff,   dsh_in;
   logic [hsvws_pkg::MEAN_W-1:0]  quot_ff,  quot_in;
   logic [SW:0]                   trial;

   // the mean never exceeds a channel maximum, so the divisor starts shifted
   // by one less than the quotient width
   assign trial = {1'b0, rem_ff} - {1'b0, dsh_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = hsvws_pkg::STEP_W'(hsvws_pkg::DIV_STEPS - 1);
         rem_in  = dividend;
         dsh_in  = SW'(divisor) << (hsvws_pkg::DIV_STEPS - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[hsvws_pkg::MEAN_W-2:0], ~trial[SW]};
         if (!trial[SW]) begin
            rem_in = trial[SW-1:0];
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
